@@ hdl/mpq_pkg.sv @@
// shared types, status codes and defaults for the min priority queue
package mpq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int ENTRY_W       = 64;

    // operation codes
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_DRAIN = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_REMOVED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic signed [31:0] pri;
        logic signed [31:0] val;
    } entry_t;

endpackage

@@ hdl/mpq_ram.sv @@
// generic simple dual port ram with registered read
module mpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/min_priority_queue_core.sv @@
// bounded min priority queue kept sorted in a ram, least entry at the top
//
//   channel  signals                                   direction
//   in       valid ready func value priority_req         sink
//   out      out_valid out_ready out_value out_priority  source
//            status last
//
// push: each stored entry whose priority is not greater than the new one
// is moved up one slot (one ram read and write a cycle), then the new one is written
// pop and drain: one ram read per entry returned, each read issued once
// the output is free
// the ram holds entries in descending order, so the least sits at count-1
// reset clears only the count and control; ram contents need no clearing
// a result waits in the output register; no new beat is taken until it leaves
module min_priority_queue_core
    import mpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] value,
    input  logic signed [31:0] priority_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_priority,
    output logic [1:0]         status,
    output logic               last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);
    localparam logic [CW-1:0] TWO      = CW'(2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_PFIN  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          drain_reg, drain_next;
    entry_t        new_reg, new_next;
    logic          ov_reg, ov_next;
    entry_t        oe_reg, oe_next;
    logic [1:0]    ost_reg, ost_next;
    logic          olast_reg, olast_next;

    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
    entry_t        rdata;
    logic          in_beat;

    mpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign ready        = (state_reg == S_IDLE) && !ov_reg;
    assign in_beat      = valid && ready;
    assign out_valid    = ov_reg;
    assign out_value    = oe_reg.val;
    assign out_priority = oe_reg.pri;
    assign status       = ost_reg;
    assign last         = olast_reg;

    // read address: next lower entry during insertion, else the top
    always_comb
    begin
        if (state_reg == S_PUSH)
        begin
            raddr = AW'(pos_reg - TWO);
        end
        else
        begin
            raddr = AW'(cnt_reg - ONE);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        drain_next = drain_reg;
        new_next   = new_reg;
        ov_next    = ov_reg;
        oe_next    = oe_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;
        we         = 1'b0;
        waddr      = AW'(pos_reg);
        wdata      = new_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    new_next.val = value;
                    new_next.pri = priority_req;
                    oe_next      = '0;
                    olast_next   = 1'b1;
                    case (func)
                        FUNC_PUSH:
                        begin
                            if (cnt_reg == FULL_CNT)
                            begin
                                ov_next  = 1'b1;
                                ost_next = ST_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                we          = 1'b1;
                                waddr       = '0;
                                wdata.val   = value;
                                wdata.pri   = priority_req;
                                cnt_next    = ONE;
                                ov_next     = 1'b1;
                                ost_next    = ST_PUSHED;
                            end
                            else
                            begin
                                pos_next   = cnt_reg;
                                state_next = S_PUSH;
                            end
                        end
                        FUNC_POP, FUNC_DRAIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                ov_next  = 1'b1;
                                ost_next = ST_EMPTY;
                            end
                            else
                            begin
                                drain_next = (func == FUNC_DRAIN);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                we = 1'b1;
                if (rdata.pri <= new_reg.pri)
                begin
                    // older entry is served first: move it up a slot
                    waddr    = AW'(pos_reg);
                    wdata    = rdata;
                    pos_next = pos_reg - ONE;
                    if (pos_reg == ONE)
                    begin
                        state_next = S_PFIN;
                    end
                end
                else
                begin
                    waddr      = AW'(pos_reg);
                    wdata      = new_reg;
                    cnt_next   = cnt_reg + ONE;
                    ov_next    = 1'b1;
                    ost_next   = ST_PUSHED;
                    oe_next    = '0;
                    state_next = S_IDLE;
                end
            end
            S_PFIN:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = new_reg;
                cnt_next   = cnt_reg + ONE;
                ov_next    = 1'b1;
                ost_next   = ST_PUSHED;
                oe_next    = '0;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                oe_next    = rdata;
                ost_next   = ST_REMOVED;
                olast_next = !drain_reg || (cnt_reg == ONE);
                ov_next    = 1'b1;
                cnt_next   = cnt_reg - ONE;
                if (drain_reg && (cnt_reg != ONE))
                begin
                    state_next = S_DWAIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DWAIT:
            begin
                // read of the next entry is issued once the output is free
                if (!ov_reg)
                begin
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        drain_reg <= drain_next;
        new_reg   <= new_next;
        oe_reg    <= oe_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

endmodule
